/* hw/rtl/pcm_pkg.sv */
`default_nettype none

package pcm_pkg;

  localparam int LEVEL_BITS_DEF = 16;
  localparam int SAMPLE_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int WINDOW_LIMIT = 2048;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT = 2'd2;

  localparam logic [15:0] RANGE_MIN_RST = 16'd0;
  localparam logic [15:0] RANGE_MAX_RST = 16'd4095;
  localparam logic [15:0] LEVEL_COUNT_RST = 16'd256;

  // floor(x/5) = (x * ceil(2^22/5)) >> 22, exact for x < 2^22
  localparam logic [19:0] DIV5_MUL = 20'd838861;
  localparam int DIV5_SHIFT = 22;

  localparam logic [7:0] CH_MAX = 8'd255;
  localparam int RISE_MUL = 1275;
  localparam int FALL_MUL = 5100;

  typedef enum logic [1:0] {
    SEG_RED_GREEN = 2'd0,
    SEG_GREEN_RED = 2'd1,
    SEG_GREEN_BLUE = 2'd2,
    SEG_BLUE_GREEN = 2'd3
  } seg_t;

  typedef struct packed {
    logic valid;
    logic bad;
    logic fe;
    logic zero;
    logic sat;
  } lvl_side_t;

  typedef struct packed {
    logic valid;
    logic bad;
    logic fe;
    seg_t seg;
    logic csat;
  } col_side_t;

  function automatic logic [17:0] pcm_div5(input logic [17:0] x);
    logic [37:0] p;
    p = 38'(x) * 38'(DIV5_MUL);
    return 18'(p >> DIV5_SHIFT);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/pcm_div.sv */
`default_nettype none

module pcm_div import pcm_pkg::*; #(
  parameter int DB = 16,
  parameter int QB = 16,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic [DB+QB-1:0]  num,
  input  wire logic [DB-1:0]     den,
  input  wire logic [SIDE_W-1:0] side_in,
  output logic [QB-1:0]          quo,
  output logic [SIDE_W-1:0]      side_out
);

  // num must be below den << QB; one quotient bit per stage
  logic [DB-1:0]     rem_p  [QB+1];
  logic [QB-1:0]     lo_p   [QB+1];
  logic [DB-1:0]     den_p  [QB+1];
  logic [SIDE_W-1:0] side_p [QB+1];

  assign rem_p[0]  = num[DB+QB-1:QB];
  assign lo_p[0]   = num[QB-1:0];
  assign den_p[0]  = den;
  assign side_p[0] = side_in;

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [DB:0] t;
    logic [DB:0] d;
    logic        ge;
    assign t  = {rem_p[k], lo_p[k][QB-1]};
    assign d  = t - {1'b0, den_p[k]};
    assign ge = t >= {1'b0, den_p[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_p[k+1] <= ge ? d[DB-1:0] : t[DB-1:0];
        lo_p[k+1]  <= (lo_p[k] << 1) | QB'(ge);
        den_p[k+1] <= den_p[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        side_p[k+1] <= '0;
      end else if (en) begin
        side_p[k+1] <= side_p[k];
      end
    end
  end

  assign quo      = lo_p[QB];
  assign side_out = side_p[QB];

endmodule

`default_nettype wire

/* hw/rtl/int16_pseudocolor_mapper.sv */
// Pipeline: 4 front stages, LEVEL_BITS level divider stages, 3 color stages,
// 8 color divider stages and an output register.
// Throughput: one pixel per clock while the output is not stalled.
// The two restoring dividers retire one quotient bit per pipeline stage.
// A stall on the output freezes every stage at once. Synchronous reset clears
// all valid bits and loads the register defaults; no clearing pass is needed.
`default_nettype none

module int16_pseudocolor_mapper import pcm_pkg::*; #(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [15:0]   sample,
  input  wire logic                 frame_end,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [7:0]                red,
  output logic [7:0]                green,
  output logic [7:0]                blue,
  output logic                      out_of_range,
  output logic                      frame_end_out
);

  localparam int LB = LEVEL_BITS;
  localparam int DW = 18;
  localparam int PW = DW + LB + 1;
  localparam int CW = LB + 13;
  localparam int CDB = LB + 1;

  logic signed [15:0] range_min, range_max;
  logic [15:0]        level_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_min   <= RANGE_MIN_RST;
      range_max   <= RANGE_MAX_RST;
      level_count <= LEVEL_COUNT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RANGE_MIN:   range_min <= cfg_data;
        REG_RANGE_MAX:   range_max <= cfg_data;
        REG_LEVEL_COUNT: level_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // derived constants, updated in the cycle after the registers
  logic [LB-1:0] nn, nm1, s1, s2, s3;
  logic [LB:0]   twon;
  logic [LB-1:0] n_raw;
  assign n_raw = level_count[LB-1:0];

  always_ff @(posedge clk) begin
    nn   <= (n_raw == '0) ? LB'(1) : n_raw;
    nm1  <= (n_raw == '0) ? '0 : n_raw - LB'(1);
    twon <= (n_raw == '0) ? (LB+1)'(2) : {n_raw, 1'b0};
    s1   <= LB'(pcm_div5(18'(n_raw) << 1));
    s2   <= n_raw >> 1;
    s3   <= LB'(pcm_div5(18'(n_raw) * 18'd3));
  end
  // a zero count acts as one: all thresholds are zero then too

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 0: capture, window check, differences
  logic                 v0, bad0, fe0;
  logic signed [DW-1:0] diff0, den0;
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      bad0  <= !(sample > -16'sd2048 && sample < 16'sd2048);
      fe0   <= frame_end;
      diff0 <= DW'(sample) - DW'(range_min);
      den0  <= DW'(range_max) - DW'(range_min);
    end
  end

  // stage 1: scale by level count
  logic                 v1, bad1, fe1;
  logic signed [PW-1:0] prod1;
  logic signed [DW-1:0] den1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= v0;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      bad1  <= bad0;
      fe1   <= fe0;
      prod1 <= PW'(diff0) * PW'($signed({1'b0, nn}));
      den1  <= den0;
    end
  end

  // stage 2: fold the sign of the span into the numerator
  logic                 v2, bad2, fe2;
  logic signed [PW-1:0] prod2;
  logic signed [DW-1:0] den2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      bad2  <= bad1;
      fe2   <= fe1;
      prod2 <= den1[DW-1] ? -prod1 : prod1;
      den2  <= den1[DW-1] ? -den1 : den1;
    end
  end

  // stage 3: zero and overflow detection ahead of the divider
  lvl_side_t            side3;
  logic [LB+15:0]       num3;
  logic [15:0]          dd3;
  always_ff @(posedge clk) begin
    if (rst) side3 <= '0;
    else if (en) begin
      side3.valid <= v2;
      side3.bad   <= bad2;
      side3.fe    <= fe2;
      side3.zero  <= (den2 == '0) || prod2[PW-1] || (prod2 == '0);
      side3.sat   <= prod2 >= PW'($signed({den2, {LB{1'b0}}}));
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      num3 <= prod2[LB+15:0];
      dd3  <= den2[15:0];
    end
  end

  logic [LB-1:0] q_lvl;
  lvl_side_t     side_lvl;
  logic [$bits(lvl_side_t)-1:0] side_lvl_raw;

  pcm_div #(.DB(16), .QB(LB), .SIDE_W($bits(lvl_side_t))) u_lvl_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .num      (num3),
    .den      (dd3),
    .side_in  (side3),
    .quo      (q_lvl),
    .side_out (side_lvl_raw)
  );
  assign side_lvl = lvl_side_t'(side_lvl_raw);

  // stage 4: clamp the level
  logic          v4, bad4, fe4;
  logic [LB-1:0] l4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= side_lvl.valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      bad4 <= side_lvl.bad;
      fe4  <= side_lvl.fe;
      priority if (side_lvl.zero) l4 <= '0;
      else if (side_lvl.sat || q_lvl > nm1) l4 <= nm1;
      else l4 <= q_lvl;
    end
  end

  // stage 5: pick the segment and its ramp numerator over 2N
  logic          v5, bad5, fe5;
  seg_t          seg5;
  logic [CW-1:0] cnum5;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      bad5 <= bad4;
      fe5  <= fe4;
      priority if (l4 < s1) begin
        seg5  <= SEG_RED_GREEN;
        cnum5 <= CW'(l4) * CW'(RISE_MUL);
      end else if (l4 < s2) begin
        seg5  <= SEG_GREEN_RED;
        cnum5 <= CW'(s2 - l4) * CW'(FALL_MUL);
      end else if (l4 < s3) begin
        seg5  <= SEG_GREEN_BLUE;
        cnum5 <= CW'(l4 - s2) * CW'(FALL_MUL);
      end else begin
        seg5  <= SEG_BLUE_GREEN;
        cnum5 <= CW'(nn - l4) * CW'(RISE_MUL);
      end
    end
  end

  // stage 6: cap check against 256 * 2N
  col_side_t      side6;
  logic [LB+8:0]  num6;
  logic [CDB-1:0] den6;
  always_ff @(posedge clk) begin
    if (rst) side6 <= '0;
    else if (en) begin
      side6.valid <= v5;
      side6.bad   <= bad5;
      side6.fe    <= fe5;
      side6.seg   <= seg5;
      side6.csat  <= cnum5 >= CW'({twon, 8'd0});
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      num6 <= cnum5[LB+8:0];
      den6 <= twon;
    end
  end

  logic [7:0] q_col;
  col_side_t  side_col;
  logic [$bits(col_side_t)-1:0] side_col_raw;

  pcm_div #(.DB(CDB), .QB(8), .SIDE_W($bits(col_side_t))) u_col_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .num      (num6),
    .den      (den6),
    .side_in  (side6),
    .quo      (q_col),
    .side_out (side_col_raw)
  );
  assign side_col = col_side_t'(side_col_raw);

  // output register
  logic [7:0] ramp;
  assign ramp = side_col.csat ? CH_MAX : q_col;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= side_col.valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_of_range  <= side_col.bad;
      frame_end_out <= side_col.fe;
      if (side_col.bad) begin
        red   <= '0;
        green <= '0;
        blue  <= '0;
      end else begin
        unique case (side_col.seg)
          SEG_RED_GREEN:  begin red <= CH_MAX; green <= ramp;   blue <= '0;     end
          SEG_GREEN_RED:  begin red <= ramp;   green <= CH_MAX; blue <= '0;     end
          SEG_GREEN_BLUE: begin red <= '0;     green <= CH_MAX; blue <= ramp;   end
          SEG_BLUE_GREEN: begin red <= '0;     green <= ramp;   blue <= CH_MAX; end
          default:        begin red <= '0;     green <= '0;     blue <= '0;     end
        endcase
      end
    end
  end

  a_black: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> red == '0 && green == '0 && blue == '0)
    else $error("out-of-range pixel not black");

  a_full_chan: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_of_range |-> red == CH_MAX || green == CH_MAX || blue == CH_MAX)
    else $error("mapped pixel has no full channel");

  a_level_cap: assert property (@(posedge clk) disable iff (rst)
    v4 && !bad4 |-> l4 <= nm1)
    else $error("level above last level");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    v4 && !en |=> v4 && $stable(l4))
    else $error("level stage moved during stall");

endmodule

`default_nettype wire
